// ===== src/pnu_pkg.sv =====
// shared types and constants for the palette nearest-neighbor upscaler
`timescale 1ns / 1ps
package pnu_pkg;

	// default storage sizes
	localparam int FRAME_DEPTH_DEF  = 65536;
	localparam int PALETTE_SIZE_DEF = 256;

	// field widths
	localparam int CMD_W    = 2;
	localparam int IDX_W    = 8;
	localparam int RGB_W    = 24;
	localparam int PADDR_W  = 16;
	localparam int POS_W    = 14;
	localparam int SRC_W    = 11;
	localparam int WIN_W    = 15;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 15;

	// scaled coordinate product and source address widths
	localparam int PROD_W = POS_W + SRC_W;
	localparam int SADDR_W = 2 * SRC_W + 1;

	// commands
	localparam logic [CMD_W-1:0] CMD_PAL_WR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PIX_WR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_EMIT   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_X     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_Y     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_W     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_H     = 3'd7;

	// register reset values
	localparam logic [SRC_W-1:0] SRC_WIDTH_RST  = 11'd320;
	localparam logic [SRC_W-1:0] SRC_HEIGHT_RST = 11'd200;
	localparam logic [WIN_W-1:0] WIN_WIDTH_RST  = 15'd640;
	localparam logic [WIN_W-1:0] WIN_HEIGHT_RST = 15'd400;
	localparam logic [POS_W-1:0] RECT_X_RST     = 14'd0;
	localparam logic [POS_W-1:0] RECT_Y_RST     = 14'd0;
	localparam logic [WIN_W-1:0] RECT_W_RST     = 15'd640;
	localparam logic [WIN_W-1:0] RECT_H_RST     = 15'd400;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_ADDR,
		ST_FREAD,
		ST_PREAD,
		ST_PDATA,
		ST_FIN
	} state_t;

endpackage

// ===== src/pnu_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module pnu_div #(
	parameter int NUM_W = pnu_pkg::PROD_W,
	parameter int DEN_W = pnu_pkg::WIN_W,
	parameter int QUO_W = pnu_pkg::SRC_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [QUO_W-1:0] quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CNT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], fits};
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
		end
	end

	assign busy = busy_q;
	assign quo  = num_q[QUO_W-1:0];
endmodule

// ===== src/pnu_frame_ram.sv =====
// indexed source frame memory, one write and one registered read port
`timescale 1ns / 1ps
module pnu_frame_ram #(
	parameter int FRAME_DEPTH = pnu_pkg::FRAME_DEPTH_DEF,
	parameter int AW = $clog2(FRAME_DEPTH)
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [pnu_pkg::IDX_W-1:0] wdata,
	input  logic                     re,
	input  logic [AW-1:0]            raddr,
	output logic [pnu_pkg::IDX_W-1:0] rdata
);
	logic [pnu_pkg::IDX_W-1:0] mem [FRAME_DEPTH];
	logic [pnu_pkg::IDX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== src/pnu_pal_ram.sv =====
// palette memory with per-entry valid bits so reset reads as black
`timescale 1ns / 1ps
module pnu_pal_ram #(
	parameter int PALETTE_SIZE = pnu_pkg::PALETTE_SIZE_DEF,
	parameter int PW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     we,
	input  logic [PW-1:0]            waddr,
	input  logic [pnu_pkg::RGB_W-1:0] wdata,
	input  logic                     re,
	input  logic [PW-1:0]            raddr,
	output logic [pnu_pkg::RGB_W-1:0] rdata
);
	logic [pnu_pkg::RGB_W-1:0] mem [PALETTE_SIZE];
	logic [PALETTE_SIZE-1:0]  valid_q;
	logic [pnu_pkg::RGB_W-1:0] rdata_q;
	logic                     rvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we)
				valid_q[waddr] <= 1'b1;
			if (re)
				rvalid_q <= valid_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	// entries never written since reset read as zero
	assign rdata = rvalid_q ? rdata_q : '0;
endmodule

// ===== src/palette_nearest_upscaler.sv =====
// top level of the palette nearest-neighbor upscaler
// sequence: an emit outside the picture rectangle goes straight to finish; inside it runs
//   multiply, bit-serial divide, address, frame read, palette read, palette data, finish
// throughput: one transaction at a time; writes every cycle while idle; an emit stalls input
//   until finish loads the result, and out_stall holds the finish state longer
// reset: asynchronous active low; registers to defaults, scan to zero, palette black, frame kept
`timescale 1ns / 1ps
module palette_nearest_upscaler #(
	parameter int FRAME_DEPTH  = pnu_pkg::FRAME_DEPTH_DEF,
	parameter int PALETTE_SIZE = pnu_pkg::PALETTE_SIZE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration write port
	input  logic                         cfg_we,
	input  logic [pnu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pnu_pkg::CFG_DAT_W-1:0] cfg_data,
	// input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [pnu_pkg::CMD_W-1:0]     cmd,
	input  logic [pnu_pkg::IDX_W-1:0]     pal_index,
	input  logic [pnu_pkg::RGB_W-1:0]     pal_color,
	input  logic [pnu_pkg::PADDR_W-1:0]   pix_addr,
	input  logic [pnu_pkg::IDX_W-1:0]     pix_value,
	// output channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [pnu_pkg::RGB_W-1:0]     rgb,
	output logic [pnu_pkg::POS_W-1:0]     out_col,
	output logic [pnu_pkg::POS_W-1:0]     out_row,
	output logic                         line_end,
	output logic                         frame_end,
	output logic                         addr_fault
);
	localparam int AW = $clog2(FRAME_DEPTH);
	localparam int PW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
	localparam int POS_W = pnu_pkg::POS_W;
	localparam int SRC_W = pnu_pkg::SRC_W;
	localparam int WIN_W = pnu_pkg::WIN_W;
	localparam int PROD_W = pnu_pkg::PROD_W;
	localparam int SADDR_W = pnu_pkg::SADDR_W;

	// configuration registers
	logic [SRC_W-1:0] src_width_q, src_height_q;
	logic [WIN_W-1:0] win_width_q, win_height_q;
	logic [POS_W-1:0] rect_x_q, rect_y_q;
	logic [WIN_W-1:0] rect_w_q, rect_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= pnu_pkg::SRC_WIDTH_RST;
			src_height_q <= pnu_pkg::SRC_HEIGHT_RST;
			win_width_q  <= pnu_pkg::WIN_WIDTH_RST;
			win_height_q <= pnu_pkg::WIN_HEIGHT_RST;
			rect_x_q     <= pnu_pkg::RECT_X_RST;
			rect_y_q     <= pnu_pkg::RECT_Y_RST;
			rect_w_q     <= pnu_pkg::RECT_W_RST;
			rect_h_q     <= pnu_pkg::RECT_H_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pnu_pkg::REG_SRC_WIDTH:  src_width_q  <= cfg_data[SRC_W-1:0];
				pnu_pkg::REG_SRC_HEIGHT: src_height_q <= cfg_data[SRC_W-1:0];
				pnu_pkg::REG_WIN_WIDTH:  win_width_q  <= cfg_data[WIN_W-1:0];
				pnu_pkg::REG_WIN_HEIGHT: win_height_q <= cfg_data[WIN_W-1:0];
				pnu_pkg::REG_RECT_X:     rect_x_q     <= cfg_data[POS_W-1:0];
				pnu_pkg::REG_RECT_Y:     rect_y_q     <= cfg_data[POS_W-1:0];
				pnu_pkg::REG_RECT_W:     rect_w_q     <= cfg_data[WIN_W-1:0];
				pnu_pkg::REG_RECT_H:     rect_h_q     <= cfg_data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	pnu_pkg::state_t state_q, state_d;

	logic in_acc, emit_acc;
	assign in_acc   = in_valid && !in_stall;
	assign emit_acc = in_acc && (cmd == pnu_pkg::CMD_EMIT);

	// scan position and end-of-line / end-of-frame decisions
	logic [POS_W-1:0] scan_col_q, scan_row_q;
	logic [WIN_W-1:0] ww_eff, wh_eff;
	logic             lend, fend;

	assign ww_eff = (win_width_q  == '0) ? WIN_W'(1) : win_width_q;
	assign wh_eff = (win_height_q == '0) ? WIN_W'(1) : win_height_q;
	assign lend   = ({1'b0, scan_col_q} + WIN_W'(1)) >= ww_eff;
	assign fend   = lend && (({1'b0, scan_row_q} + WIN_W'(1)) >= wh_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_col_q <= '0;
			scan_row_q <= '0;
		end else if (emit_acc) begin
			if (lend) begin
				scan_col_q <= '0;
				scan_row_q <= fend ? '0 : scan_row_q + 1'b1;
			end else begin
				scan_col_q <= scan_col_q + 1'b1;
			end
		end
	end

	// picture rectangle hit test on the current scan position
	logic in_rect;
	assign in_rect = (scan_col_q >= rect_x_q)
		&& ({2'b0, scan_col_q} < ({2'b0, rect_x_q} + {1'b0, rect_w_q}))
		&& (scan_row_q >= rect_y_q)
		&& ({2'b0, scan_row_q} < ({2'b0, rect_y_q} + {1'b0, rect_h_q}));

	// per-transaction registers
	logic [POS_W-1:0]          col_q, row_q, dx_q, dy_q;
	logic                      lend_q, fend_q;
	logic [pnu_pkg::RGB_W-1:0] res_rgb_q;
	logic                      res_fault_q;
	logic [SADDR_W-1:0]        addr_q;

	// source column and row dividers
	logic [PROD_W-1:0] num_x, num_y;
	logic              busy_x, busy_y;
	logic [SRC_W-1:0]  src_col, src_row;
	logic              div_start;

	assign num_x     = PROD_W'(dx_q) * PROD_W'(src_width_q);
	assign num_y     = PROD_W'(dy_q) * PROD_W'(src_height_q);
	assign div_start = (state_q == pnu_pkg::ST_MUL);

	pnu_div #(.NUM_W(PROD_W), .DEN_W(WIN_W), .QUO_W(SRC_W)) u_div_x (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(num_x), .den(rect_w_q), .busy(busy_x), .quo(src_col)
	);

	pnu_div #(.NUM_W(PROD_W), .DEN_W(WIN_W), .QUO_W(SRC_W)) u_div_y (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(num_y), .den(rect_h_q), .busy(busy_y), .quo(src_row)
	);

	logic [2*SRC_W-1:0] row_base;
	logic [SADDR_W-1:0] addr_d;
	logic               addr_bad;

	assign row_base = (2*SRC_W)'(src_row) * (2*SRC_W)'(src_width_q);
	assign addr_d   = SADDR_W'(row_base) + SADDR_W'(src_col);
	assign addr_bad = addr_q >= SADDR_W'(FRAME_DEPTH);

	// frame store
	logic                      frame_we, frame_re;
	logic [pnu_pkg::IDX_W-1:0] frame_rdata;

	assign frame_we = in_acc && (cmd == pnu_pkg::CMD_PIX_WR)
		&& ({5'b0, pix_addr} < 21'(FRAME_DEPTH));
	assign frame_re = (state_q == pnu_pkg::ST_FREAD) && !addr_bad;

	pnu_frame_ram #(.FRAME_DEPTH(FRAME_DEPTH), .AW(AW)) u_frame (
		.clk(clk), .we(frame_we), .waddr(AW'(pix_addr)), .wdata(pix_value),
		.re(frame_re), .raddr(addr_q[AW-1:0]), .rdata(frame_rdata)
	);

	// palette store
	logic                      pal_we, pal_re, idx_ok;
	logic [pnu_pkg::RGB_W-1:0] pal_rdata;

	assign pal_we = in_acc && (cmd == pnu_pkg::CMD_PAL_WR)
		&& ({1'b0, pal_index} < 9'(PALETTE_SIZE));
	assign idx_ok = {1'b0, frame_rdata} < 9'(PALETTE_SIZE);
	assign pal_re = (state_q == pnu_pkg::ST_PREAD) && idx_ok;

	pnu_pal_ram #(.PALETTE_SIZE(PALETTE_SIZE), .PW(PW)) u_pal (
		.clk(clk), .arst_n(arst_n), .we(pal_we), .waddr(pal_index[PW-1:0]),
		.wdata(pal_color), .re(pal_re), .raddr(frame_rdata[PW-1:0]), .rdata(pal_rdata)
	);

	// output register
	logic                      out_valid_q, load_out;
	logic [pnu_pkg::RGB_W-1:0] rgb_q;
	logic [POS_W-1:0]          out_col_q, out_row_q;
	logic                      line_end_q, frame_end_q, addr_fault_q;

	// sequencer: next state and strobes
	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		in_stall = 1'b1;
		case (state_q)
			pnu_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (emit_acc)
					state_d = in_rect ? pnu_pkg::ST_MUL : pnu_pkg::ST_FIN;
			end
			pnu_pkg::ST_MUL:   state_d = pnu_pkg::ST_DIV;
			pnu_pkg::ST_DIV: begin
				if (!busy_x && !busy_y)
					state_d = pnu_pkg::ST_ADDR;
			end
			pnu_pkg::ST_ADDR:  state_d = pnu_pkg::ST_FREAD;
			pnu_pkg::ST_FREAD: state_d = addr_bad ? pnu_pkg::ST_FIN : pnu_pkg::ST_PREAD;
			pnu_pkg::ST_PREAD: state_d = idx_ok ? pnu_pkg::ST_PDATA : pnu_pkg::ST_FIN;
			pnu_pkg::ST_PDATA: state_d = pnu_pkg::ST_FIN;
			pnu_pkg::ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = pnu_pkg::ST_IDLE;
				end
			end
			default: state_d = pnu_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= pnu_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// transaction datapath
	always_ff @(posedge clk) begin
		if (emit_acc) begin
			col_q       <= scan_col_q;
			row_q       <= scan_row_q;
			lend_q      <= lend;
			fend_q      <= fend;
			dx_q        <= scan_col_q - rect_x_q;
			dy_q        <= scan_row_q - rect_y_q;
			res_rgb_q   <= '0;
			res_fault_q <= 1'b0;
		end
		if (state_q == pnu_pkg::ST_ADDR)
			addr_q <= addr_d;
		if ((state_q == pnu_pkg::ST_FREAD) && addr_bad)
			res_fault_q <= 1'b1;
		if (state_q == pnu_pkg::ST_PDATA)
			res_rgb_q <= pal_rdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rgb_q        <= res_rgb_q;
			out_col_q    <= col_q;
			out_row_q    <= row_q;
			line_end_q   <= lend_q;
			frame_end_q  <= fend_q;
			addr_fault_q <= res_fault_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign rgb        = rgb_q;
	assign out_col    = out_col_q;
	assign out_row    = out_row_q;
	assign line_end   = line_end_q;
	assign frame_end  = frame_end_q;
	assign addr_fault = addr_fault_q;

	// a faulting pixel is always black
	a_fault_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && addr_fault_q |-> rgb_q == '0)
		else $error("addr fault with nonzero color");

	// end of frame only on the last pixel of a line
	a_fend_lend: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame_end_q |-> line_end_q)
		else $error("frame end without line end");

	// scan wraps to column zero after a line end
	a_scan_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		emit_acc && lend |=> scan_col_q == '0)
		else $error("scan column did not wrap");

	// new results only come from the finishing state
	a_load_fin: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> state_q == pnu_pkg::ST_FIN)
		else $error("result loaded outside finish state");

	// dividers never restart while running
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !busy_x && !busy_y)
		else $error("divider started while busy");
endmodule
